### hw/rtl/ilt_pkg.sv
package ilt_pkg;

    localparam int CFG_W = 7;

    typedef enum logic [1:0] {
        CFG_INT_WIDTH   = 2'd0,
        CFG_LONG_WIDTH  = 2'd1,
        CFG_LLONG_WIDTH = 2'd2,
        CFG_LLONG_EN    = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        TC_INT    = 3'd0,
        TC_UINT   = 3'd1,
        TC_LONG   = 3'd2,
        TC_ULONG  = 3'd3,
        TC_LLONG  = 3'd4,
        TC_ULLONG = 3'd5
    } t_type_code;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        logic [CFG_W-1:0] int_width;
        logic [CFG_W-1:0] long_width;
        logic [CFG_W-1:0] llong_width;
        logic             llong_en;
    } t_cfg;

    // Per-literal summary handed from the accumulator to the classifier.
    typedef struct packed {
        logic too_wide;
        logic is_dec;
        logic is_uns;
        logic lc_nz;
        logic lc_two;
    } t_lit_meta;

    localparam int META_W = $bits(t_lit_meta);

    typedef struct packed {
        logic f_int;
        logic f_uint;
        logic f_long;
        logic f_ulong;
        logic f_llong;
        logic f_ullong;
    } t_fits;

    typedef struct packed {
        logic       warn;
        logic       ovf;
        t_type_code code;
    } t_result;

    function automatic t_result mk_res(input t_type_code code, input logic warn);
        t_result r;
        r.code = code;
        r.ovf  = 1'b0;
        r.warn = warn;
        return r;
    endfunction

    function automatic t_result mk_ovf();
        t_result r;
        r.code = TC_INT;
        r.ovf  = 1'b1;
        r.warn = 1'b0;
        return r;
    endfunction

    function automatic t_result classify(input t_lit_meta m, input t_fits f,
                                         input logic ll);
        if (m.is_dec) begin
            if (m.is_uns) begin
                if (m.lc_nz) begin
                    if (f.f_ulong) begin
                        return m.lc_two ? mk_res(TC_ULLONG, 1'b0) : mk_res(TC_ULONG, 1'b0);
                    end
                end else begin
                    if (f.f_uint) return mk_res(TC_UINT, 1'b0);
                    if (f.f_ulong) return mk_res(TC_ULONG, 1'b0);
                end
                if (ll && f.f_ullong) return mk_res(TC_ULLONG, 1'b0);
                return mk_ovf();
            end
            if (m.lc_nz) begin
                if (f.f_long) begin
                    return m.lc_two ? mk_res(TC_LLONG, 1'b0) : mk_res(TC_LONG, 1'b0);
                end
                if (f.f_ulong) begin
                    if (!m.lc_two) return mk_res(TC_ULONG, 1'b0);
                    return f.f_llong ? mk_res(TC_LLONG, 1'b0) : mk_res(TC_ULLONG, 1'b0);
                end
            end else begin
                if (f.f_int) return mk_res(TC_INT, 1'b0);
                if (f.f_long) return mk_res(TC_LONG, 1'b0);
                if (f.f_ulong) return mk_res(TC_ULONG, 1'b0);
            end
            if (!ll) return mk_ovf();
            if (f.f_llong) return mk_res(TC_LLONG, 1'b0);
            if (f.f_ullong) return mk_res(TC_ULLONG, 1'b1);
            return mk_ovf();
        end
        if (m.is_uns) begin
            if (m.lc_nz) begin
                if (!m.lc_two && f.f_ulong) return mk_res(TC_ULONG, 1'b0);
            end else begin
                if (f.f_uint) return mk_res(TC_UINT, 1'b0);
                if (f.f_ulong) return mk_res(TC_ULONG, 1'b0);
            end
            if (ll && f.f_ullong) return mk_res(TC_ULLONG, 1'b0);
            return mk_ovf();
        end
        if (!m.lc_nz) begin
            if (f.f_int) return mk_res(TC_INT, 1'b0);
            if (f.f_uint) return mk_res(TC_UINT, 1'b0);
        end
        if (!m.lc_two) begin
            if (f.f_long) return mk_res(TC_LONG, 1'b0);
            if (f.f_ulong) return mk_res(TC_ULONG, 1'b0);
        end
        if (!ll) return mk_ovf();
        if (f.f_llong) return mk_res(TC_LLONG, 1'b0);
        if (f.f_ullong) return mk_res(TC_ULLONG, 1'b0);
        return mk_ovf();
    endfunction

    function automatic logic [CFG_W-1:0] clamp_w(input logic [CFG_W-1:0] w,
                                                 input logic [CFG_W-1:0] lo);
        if (w < lo) return lo;
        if (w > CFG_W'(64)) return CFG_W'(64);
        return w;
    endfunction

endpackage

### hw/rtl/ilt_front.sv
module ilt_front #(
    parameter int VALUE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [3:0]                    i_digit,
    input  logic [1:0]                    i_radix,
    input  logic                          i_is_unsigned,
    input  logic [1:0]                    i_long_count,
    input  logic                          i_last,
    output logic                          o_push,
    output logic [VALUE_BITS-1:0]         o_value,
    output ilt_pkg::t_lit_meta            o_meta
);

    localparam int EXT_W = VALUE_BITS + 4;

    logic [VALUE_BITS-1:0] r_acc;
    logic [VALUE_BITS-1:0] n_acc;
    logic                  r_wide;
    logic                  n_wide;
    logic [EXT_W-1:0]      acc_ext;
    logic [EXT_W-1:0]      prod;
    logic [EXT_W-1:0]      sum;

    assign acc_ext = EXT_W'(r_acc);

    always_comb begin
        unique case (i_radix)
            ilt_pkg::RADIX_DEC: prod = (acc_ext << 3) + (acc_ext << 1);
            ilt_pkg::RADIX_OCT: prod = acc_ext << 3;
            default:            prod = acc_ext << 4;
        endcase
        sum    = prod + EXT_W'(i_digit);
        n_wide = r_wide | (|sum[EXT_W-1:VALUE_BITS]);
        n_acc  = sum[VALUE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_wide <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_acc  <= '0;
                r_wide <= 1'b0;
            end else begin
                r_acc  <= n_acc;
                r_wide <= n_wide;
            end
        end
    end

    assign o_push          = i_accept & i_last;
    assign o_value         = n_acc;
    assign o_meta.too_wide = n_wide;
    assign o_meta.is_dec   = (i_radix == ilt_pkg::RADIX_DEC);
    assign o_meta.is_uns   = i_is_unsigned;
    assign o_meta.lc_nz    = (i_long_count != 2'd0);
    assign o_meta.lc_two   = i_long_count[1];

endmodule

### hw/rtl/ilt_queue.sv
module ilt_queue #(
    parameter int DATA_W = 69
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

### hw/rtl/ilt_back.sv
module ilt_back #(
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ilt_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    input  logic [VALUE_BITS-1:0] i_value,
    input  ilt_pkg::t_lit_meta    i_meta,
    output logic                  o_pop,
    output logic                  o_valid,
    output ilt_pkg::t_result      o_result,
    input  logic                  i_ready
);

    localparam int CW = ilt_pkg::CFG_W;

    logic                 r_valid;
    ilt_pkg::t_result     r_result;
    logic [CW-1:0]        wi;
    logic [CW-1:0]        wl;
    logic [CW-1:0]        wll;
    ilt_pkg::t_fits       fits;

    function automatic logic fits_below(input logic [VALUE_BITS-1:0] v,
                                        input logic [CW-1:0] lim);
        logic bad;
        bad = 1'b0;
        for (int k = 0; k < VALUE_BITS; k++) begin
            bad = bad | (v[k] & (CW'(k) >= lim));
        end
        return !bad;
    endfunction

    always_comb begin
        wi  = ilt_pkg::clamp_w(i_cfg.int_width, CW'(8));
        wl  = ilt_pkg::clamp_w(i_cfg.long_width, CW'(16));
        wll = ilt_pkg::clamp_w(i_cfg.llong_width, CW'(32));
        fits.f_int    = !i_meta.too_wide && fits_below(i_value, wi - CW'(1));
        fits.f_uint   = !i_meta.too_wide && fits_below(i_value, wi);
        fits.f_long   = !i_meta.too_wide && fits_below(i_value, wl - CW'(1));
        fits.f_ulong  = !i_meta.too_wide && fits_below(i_value, wl);
        fits.f_llong  = !i_meta.too_wide && fits_below(i_value, wll - CW'(1));
        fits.f_ullong = !i_meta.too_wide && fits_below(i_value, wll);
    end

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= ilt_pkg::classify(i_meta, fits, i_cfg.llong_en);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hw/rtl/integer_literal_type_classifier_core.sv
// Classifies C integer literals streamed one digit per beat, most significant
// digit first, with the literal's base and suffixes riding on every beat and
// tlast on the final digit. The accumulator takes one digit every cycle with
// no gaps between literals while the queue is not full; on the last digit it
// hands the value to a two-entry queue, and a classifier takes it from the
// queue head and registers one result beat per literal: the first C type that
// holds the value, an overflow flag and a warning for a signed decimal literal
// that becomes unsigned long long without fitting unsigned long. Input stalls
// only while the queue holds two literals that the classifier has not taken.
// Type widths are set through the configuration channel; the user must do so
// only while no literal is in flight, as the block does not enforce it.
module integer_literal_type_classifier_core #(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // digit[3:0], radix[5:4], is_unsigned[6],
                                       // long_count[8:7], zero fill
    input  logic        s_axis_tlast,  // last_digit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // type_code[2:0], overflow[3],
                                       // ullong_warning[4], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    localparam int Q_W = VALUE_BITS + ilt_pkg::META_W;

    ilt_pkg::t_cfg         r_cfg;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic                  push;
    logic [VALUE_BITS-1:0] push_value;
    ilt_pkg::t_lit_meta    push_meta;
    logic [Q_W-1:0]        q_data;
    logic [VALUE_BITS-1:0] head_value;
    ilt_pkg::t_lit_meta    head_meta;
    ilt_pkg::t_result      result;
    logic                  s_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.int_width   <= ilt_pkg::CFG_W'(32);
            r_cfg.long_width  <= ilt_pkg::CFG_W'(64);
            r_cfg.llong_width <= ilt_pkg::CFG_W'(64);
            r_cfg.llong_en    <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (ilt_pkg::t_cfg_index'(i_cfg_index))
                ilt_pkg::CFG_INT_WIDTH:   r_cfg.int_width   <= i_cfg_data;
                ilt_pkg::CFG_LONG_WIDTH:  r_cfg.long_width  <= i_cfg_data;
                ilt_pkg::CFG_LLONG_WIDTH: r_cfg.llong_width <= i_cfg_data;
                ilt_pkg::CFG_LLONG_EN:    r_cfg.llong_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    ilt_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_digit       (s_axis_tdata[3:0]),
        .i_radix       (s_axis_tdata[5:4]),
        .i_is_unsigned (s_axis_tdata[6]),
        .i_long_count  (s_axis_tdata[8:7]),
        .i_last        (s_axis_tlast),
        .o_push        (push),
        .o_value       (push_value),
        .o_meta        (push_meta)
    );

    ilt_queue #(.DATA_W(Q_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_value, push_meta}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign head_value = q_data[Q_W-1:ilt_pkg::META_W];
    assign head_meta  = ilt_pkg::t_lit_meta'(q_data[ilt_pkg::META_W-1:0]);

    ilt_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (q_valid),
        .i_value  (head_value),
        .i_meta   (head_meta),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .o_result (result),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, result.warn, result.ovf, result.code};

endmodule

### hw/rtl/ilt_checker.sv
module ilt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    a_ovf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |->
            (m_axis_tdata[2:0] == 3'd0 && !m_axis_tdata[4]))
        else $error("overflow beat carries a type or a warning");

    a_warn_ullong: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tdata[2:0] == 3'd5))
        else $error("warning on a type other than unsigned long long");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd5 && m_axis_tdata[7:5] == 3'd0))
        else $error("result beat out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind integer_literal_type_classifier_core ilt_checker u_ilt_checker (.*);

### sim/tb_integer_literal_type_classifier_core.sv
module tb_integer_literal_type_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;

    bit quiet;
    bit calm;
    int beats_sent;

    typedef struct {
        ilt_pkg::t_type_code code;
        bit                  ovf;
        bit                  warn;
    } t_lit_type;

    class literal_type_checker;
        logic [6:0]  int_w    = 7'd32;
        logic [6:0]  long_w   = 7'd64;
        logic [6:0]  llong_w  = 7'd64;
        bit          llong_on = 1'b1;
        logic [63:0] value    = '0;
        bit          too_wide;
        t_lit_type   pending_types[$];
        int          errors;

        function int sat_width(logic [6:0] w, int lo);
            if (w < lo) return lo;
            if (w > 64) return 64;
            return int'(w);
        endfunction

        function bit holds(int w, bit sgn);
            logic [63:0] top;
            top = sgn ? ({64{1'b1}} >> (65 - w)) : ({64{1'b1}} >> (64 - w));
            return !too_wide && (value <= top);
        endfunction

        function void write_reg(ilt_pkg::t_cfg_index idx, logic [6:0] data);
            case (idx)
                ilt_pkg::CFG_INT_WIDTH:   int_w = data;
                ilt_pkg::CFG_LONG_WIDTH:  long_w = data;
                ilt_pkg::CFG_LLONG_WIDTH: llong_w = data;
                ilt_pkg::CFG_LLONG_EN:    llong_on = data[0];
            endcase
        endfunction

        function t_lit_type pick(ilt_pkg::t_type_code c, bit w);
            t_lit_type r;
            r.code = c;
            r.ovf  = 1'b0;
            r.warn = w;
            return r;
        endfunction

        function t_lit_type classify_literal(ilt_pkg::t_radix rdx, bit uns, int lc);
            t_lit_type none;
            bit fi, fui, fl, ful, fq, fuq;
            none.code = ilt_pkg::TC_INT;
            none.ovf  = 1'b1;
            none.warn = 1'b0;
            fi  = holds(sat_width(int_w, 8), 1'b1);
            fui = holds(sat_width(int_w, 8), 1'b0);
            fl  = holds(sat_width(long_w, 16), 1'b1);
            ful = holds(sat_width(long_w, 16), 1'b0);
            fq  = holds(sat_width(llong_w, 32), 1'b1);
            fuq = holds(sat_width(llong_w, 32), 1'b0);
            if (rdx == ilt_pkg::RADIX_DEC) begin
                if (uns) begin
                    if (lc != 0 && ful) begin
                        return (lc == 1) ? pick(ilt_pkg::TC_ULONG, 1'b0)
                                         : pick(ilt_pkg::TC_ULLONG, 1'b0);
                    end
                    if (lc == 0 && fui) return pick(ilt_pkg::TC_UINT, 1'b0);
                    if (lc == 0 && ful) return pick(ilt_pkg::TC_ULONG, 1'b0);
                    if (llong_on && fuq) return pick(ilt_pkg::TC_ULLONG, 1'b0);
                    return none;
                end
                if (lc != 0 && fl) begin
                    return (lc == 1) ? pick(ilt_pkg::TC_LONG, 1'b0)
                                     : pick(ilt_pkg::TC_LLONG, 1'b0);
                end
                if (lc != 0 && ful) begin
                    if (lc == 1) return pick(ilt_pkg::TC_ULONG, 1'b0);
                    return fq ? pick(ilt_pkg::TC_LLONG, 1'b0)
                              : pick(ilt_pkg::TC_ULLONG, 1'b0);
                end
                if (lc == 0 && fi) return pick(ilt_pkg::TC_INT, 1'b0);
                if (lc == 0 && fl) return pick(ilt_pkg::TC_LONG, 1'b0);
                if (lc == 0 && ful) return pick(ilt_pkg::TC_ULONG, 1'b0);
                if (!llong_on) return none;
                if (fq) return pick(ilt_pkg::TC_LLONG, 1'b0);
                if (fuq) return pick(ilt_pkg::TC_ULLONG, 1'b1);
                return none;
            end
            if (uns) begin
                if (lc == 1 && ful) return pick(ilt_pkg::TC_ULONG, 1'b0);
                if (lc == 0 && fui) return pick(ilt_pkg::TC_UINT, 1'b0);
                if (lc == 0 && ful) return pick(ilt_pkg::TC_ULONG, 1'b0);
                if (llong_on && fuq) return pick(ilt_pkg::TC_ULLONG, 1'b0);
                return none;
            end
            if (lc == 0 && fi) return pick(ilt_pkg::TC_INT, 1'b0);
            if (lc == 0 && fui) return pick(ilt_pkg::TC_UINT, 1'b0);
            if (lc < 2 && fl) return pick(ilt_pkg::TC_LONG, 1'b0);
            if (lc < 2 && ful) return pick(ilt_pkg::TC_ULONG, 1'b0);
            if (!llong_on) return none;
            if (fq) return pick(ilt_pkg::TC_LLONG, 1'b0);
            if (fuq) return pick(ilt_pkg::TC_ULLONG, 1'b0);
            return none;
        endfunction

        function void take_digit(logic [3:0] dig, logic [1:0] radix, bit uns,
                                 logic [1:0] lc, bit last);
            ilt_pkg::t_radix rdx;
            logic [63:0]     base;
            int              lcn;
            if (radix > ilt_pkg::RADIX_HEX) rdx = ilt_pkg::RADIX_HEX;
            else rdx = ilt_pkg::t_radix'(radix);
            base = (rdx == ilt_pkg::RADIX_DEC) ? 64'd10 :
                   (rdx == ilt_pkg::RADIX_OCT) ? 64'd8 : 64'd16;
            if (value > ({64{1'b1}} - 64'(dig)) / base) too_wide = 1'b1;
            value = value * base + 64'(dig);
            if (!last) return;
            lcn = (lc == 2'd3) ? 2 : int'(lc);
            pending_types.push_back(classify_literal(rdx, uns, lcn));
            value    = '0;
            too_wide = 1'b0;
        endfunction

        function void check_type_beat(logic [7:0] beat);
            t_lit_type want;
            if (pending_types.size() == 0) begin
                $error("result beat 0x%02h arrived with no literal pending", beat);
                errors++;
                return;
            end
            want = pending_types.pop_front();
            if (beat[2:0] !== want.code) begin
                $error("type_code: expected %0d, got %0d", want.code, beat[2:0]);
                errors++;
            end
            if (beat[3] !== want.ovf) begin
                $error("overflow: expected %0d, got %0d", want.ovf, beat[3]);
                errors++;
            end
            if (beat[4] !== want.warn) begin
                $error("ullong_warning: expected %0d, got %0d", want.warn, beat[4]);
                errors++;
            end
        endfunction

        function int pending();
            return pending_types.size();
        endfunction
    endclass

    literal_type_checker sb = new();

    integer_literal_type_classifier_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_type_beat(m_axis_tdata);
    end

    initial begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                m_axis_tready = 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if (!m_axis_tready) begin
                m_axis_tready = 1'b1;
                hold = $urandom_range(0, 8);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        m_axis_tready = 1'b0;
                        hold = $urandom_range(0, 9);
                    end
                    3: hold = $urandom_range(20, 60);
                    default: hold = $urandom_range(0, 5);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_digit(logic [3:0] dig, logic [1:0] rdx, bit uns,
                              logic [1:0] lc, bit last);
        if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, lc, uns, rdx, dig};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_digit(dig, rdx, uns, lc, last);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Streams one literal: pad adds leading zeros, extra appends digits past the
    // value, bump raises the final digit by one and noisy corrupts the stream.
    task automatic send_literal(logic [63:0] v, logic [1:0] rc, bit uns, logic [1:0] lc,
                                int pad, int extra, bit bump, bit noisy);
        int unsigned dq[$];
        int          base;
        logic [1:0]  beat_rdx;
        logic [3:0]  dig;
        base = (rc == ilt_pkg::RADIX_DEC) ? 10 : (rc == ilt_pkg::RADIX_OCT) ? 8 : 16;
        do begin
            dq.push_front(int'(v % base));
            v = v / base;
        end while (v != 0);
        repeat (pad) dq.push_front(0);
        repeat (extra) dq.push_back($urandom_range(0, base - 1));
        if (bump && dq[dq.size() - 1] < 15) dq[dq.size() - 1]++;
        foreach (dq[i]) begin
            dig = 4'(dq[i]);
            if (i == dq.size() - 1) begin
                send_digit(dig, rc, uns, lc, 1'b1);
            end else begin
                if (noisy && $urandom_range(0, 7) == 0) dig = 4'($urandom_range(0, 15));
                if (noisy && $urandom_range(0, 5) == 0) beat_rdx = 2'($urandom_range(0, 3));
                else if (base == 16) beat_rdx = 2'($urandom_range(2, 3));
                else beat_rdx = rc;
                send_digit(dig, beat_rdx, 1'($urandom_range(0, 1)),
                           2'($urandom_range(0, 3)), 1'b0);
            end
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg_beat(ilt_pkg::t_cfg_index idx, logic [6:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic set_widths(logic [6:0] wi, logic [6:0] wl, logic [6:0] wq, bit en);
        logic [5:0] junk;
        junk = 6'($urandom_range(0, 63));
        write_reg_beat(ilt_pkg::CFG_INT_WIDTH, wi);
        write_reg_beat(ilt_pkg::CFG_LONG_WIDTH, wl);
        write_reg_beat(ilt_pkg::CFG_LLONG_WIDTH, wq);
        write_reg_beat(ilt_pkg::CFG_LLONG_EN, {junk, en});
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int          phase_start;
        int          w;
        logic [63:0] v;
        logic [1:0]  rc;
        int          extra;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = ilt_pkg::CFG_INT_WIDTH;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_literal(64'd0, ilt_pkg::RADIX_DEC, 1'b0, 2'd0, 0, 0, 1'b0, 1'b0);
        send_literal(64'hF, 2'd3, 1'b1, 2'd3, 0, 0, 1'b0, 1'b0);
        send_literal(64'd7, ilt_pkg::RADIX_OCT, 1'b0, 2'd1, 0, 0, 1'b0, 1'b0);
        send_literal(64'd15, ilt_pkg::RADIX_OCT, 1'b0, 2'd2, 0, 0, 1'b1, 1'b0);
        send_literal(64'h8000_0000, ilt_pkg::RADIX_HEX, 1'b0, 2'd0, 0, 0, 1'b0, 1'b0);
        send_literal(64'd4294967295, ilt_pkg::RADIX_DEC, 1'b0, 2'd0, 0, 0, 1'b0, 1'b0);

        for (int ph = 0; ph < 8; ph++) begin
            wait_drain();
            quiet = (ph == 7);
            case (ph)
                0: set_widths(7'd8, 7'd16, 7'd32, 1'b0);
                1: set_widths(7'd64, 7'd64, 7'd64, 1'b1);
                2: set_widths(7'd16, 7'd32, 7'd64, 1'b1);
                3: set_widths(7'd0, 7'd0, 7'd0, 1'b1);
                4: set_widths(7'd127, 7'd127, 7'd127, 1'b0);
                default: begin
                    if ($urandom_range(0, 1))
                        set_widths(7'($urandom_range(8, 64)), 7'($urandom_range(16, 64)),
                                   7'($urandom_range(32, 64)), 1'($urandom_range(0, 1)));
                    else
                        set_widths(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                   7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                end
            endcase
            phase_start = beats_sent;
            while (beats_sent - phase_start < 94) begin
                calm  = ($urandom_range(0, 3) == 0);
                rc    = 2'($urandom_range(0, 3));
                extra = 0;
                case ($urandom_range(0, 9))
                    0, 1: v = 64'($urandom_range(0, 1000));
                    2, 3, 4, 5: begin
                        case ($urandom_range(0, 2))
                            0: w = sb.sat_width(sb.int_w, 8);
                            1: w = sb.sat_width(sb.long_w, 16);
                            default: w = sb.sat_width(sb.llong_w, 32);
                        endcase
                        case ($urandom_range(0, 4))
                            0: v = (64'd1 << (w - 1)) - 2;
                            1: v = (64'd1 << (w - 1)) - 1;
                            2: v = 64'd1 << (w - 1);
                            3: v = (64'd1 << w) - 1;
                            default: v = 64'd1 << w;
                        endcase
                    end
                    6, 7: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                    8: begin
                        v = {$urandom, $urandom};
                        extra = $urandom_range(1, 2);
                    end
                    default: v = {64{1'b1}} - 64'($urandom_range(0, 3));
                endcase
                send_literal(v, rc, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                             ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 3)) : 0,
                             extra, $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
                if ($urandom_range(0, 29) == 0) wait_drain();
            end
        end

        wait_drain();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### integer_literal_type_classifier_core.f
hw/rtl/ilt_pkg.sv
hw/rtl/ilt_front.sv
hw/rtl/ilt_queue.sv
hw/rtl/ilt_back.sv
hw/rtl/integer_literal_type_classifier_core.sv
hw/rtl/ilt_checker.sv
sim/tb_integer_literal_type_classifier_core.sv
